@@ hdl/sme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int CAPACITY   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int SIZE_W     = 4;
    localparam int MODE_W     = 3;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ROW_BITS   = 3;
    localparam int RES_W      = 35;
    localparam int OUT_DATA_W = 48;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd8;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MAT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VEC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEG   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SCALE = 3'd5;

    typedef enum logic [2:0] {
        OP_MAC,
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_SCALE
    } op_t;

    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic                first;
        logic                last;
        logic                fin;
        logic [ROW_BITS-1:0] row;
        logic [ROW_BITS-1:0] col;
    } iss_t;

    typedef struct packed {
        logic we_a;
        logic we_b;
    } load_t;

    typedef struct packed {
        logic adv;
        logic busy;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/sme_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sme_ctrl (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 in_cmd,
    input  wire                                 in_last,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [sme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [sme_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [sme_pkg::SCALE_W-1:0]         scale_factor,
    output sme_pkg::load_t                      load,
    output logic [sme_pkg::ADDR_W-1:0]          load_addr,
    output sme_pkg::iss_t                       iss,
    output logic [sme_pkg::ADDR_W-1:0]          a_addr,
    output logic [sme_pkg::ADDR_W-1:0]          b_addr,
    input  sme_pkg::stat_t                      stat
);

    localparam int MD  = sme_pkg::MAX_DIM;
    localparam int CAP = sme_pkg::CAPACITY;
    localparam int AW  = sme_pkg::ADDR_W;
    localparam int FW  = $clog2(CAP + 1);
    localparam int IW  = (MD > 1) ? $clog2(MD) : 1;
    localparam int RB  = sme_pkg::ROW_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [sme_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [sme_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [sme_pkg::SCALE_W-1:0]   scale_reg, scale_next;
    logic [FW-1:0]                 fill_a_reg, fill_a_next;
    logic [FW-1:0]                 fill_b_reg, fill_b_next;
    logic [IW-1:0]                 i_reg, i_next;
    logic [IW-1:0]                 j_reg, j_next;
    logic [IW-1:0]                 t_reg, t_next;
    logic [AW-1:0]                 rbase_reg, rbase_next;
    logic [AW-1:0]                 tn_reg, tn_next;
    sme_pkg::iss_t                 iss_reg, iss_next;
    logic [AW-1:0]                 a_addr_reg, a_addr_next;
    logic [AW-1:0]                 b_addr_reg, b_addr_next;

    logic [IW-1:0] nm1;
    logic [AW-1:0] n_aw;
    logic          accept;
    logic          elementwise;
    logic          term_last;
    logic          col_last;
    sme_pkg::op_t  op_cur;

    always_comb begin
        if (size_reg == '0) begin
            nm1 = '0;
        end else if (size_reg > MD) begin
            nm1 = IW'(MD - 1);
        end else begin
            nm1 = IW'(size_reg - 4'd1);
        end
    end

    assign n_aw        = AW'(nm1) + AW'(1);
    assign accept      = in_valid && (state_reg == S_IDLE);
    assign elementwise = (mode_reg != sme_pkg::MODE_MAT) && (mode_reg != sme_pkg::MODE_VEC);
    assign term_last   = elementwise || (t_reg == nm1);
    assign col_last    = (mode_reg == sme_pkg::MODE_VEC) || (j_reg == nm1);

    always_comb begin
        case (mode_reg)
            sme_pkg::MODE_ADD: op_cur = sme_pkg::OP_ADD;
            sme_pkg::MODE_SUB: op_cur = sme_pkg::OP_SUB;
            sme_pkg::MODE_NEG: op_cur = sme_pkg::OP_NEG;
            sme_pkg::MODE_SCALE: op_cur = sme_pkg::OP_SCALE;
            default: op_cur = sme_pkg::OP_MAC;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        size_next   = size_reg;
        mode_next   = mode_reg;
        scale_next  = scale_reg;
        fill_a_next = fill_a_reg;
        fill_b_next = fill_b_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        t_next      = t_reg;
        rbase_next  = rbase_reg;
        tn_next     = tn_reg;
        iss_next    = iss_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        load        = '0;

        if (cfg_valid) begin
            case (cfg_index)
                sme_pkg::REG_SIZE: size_next = cfg_data[sme_pkg::SIZE_W-1:0];
                sme_pkg::REG_MODE: mode_next = cfg_data[sme_pkg::MODE_W-1:0];
                sme_pkg::REG_SCALE: scale_next = cfg_data[sme_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                iss_next.valid = 1'b0;
                if (accept) begin
                    if (!in_cmd && (fill_a_reg < FW'(CAP))) begin
                        load.we_a   = 1'b1;
                        fill_a_next = fill_a_reg + FW'(1);
                    end
                    if (in_cmd && (fill_b_reg < FW'(CAP))) begin
                        load.we_b   = 1'b1;
                        fill_b_next = fill_b_reg + FW'(1);
                    end
                    if (in_last) begin
                        fill_a_next = '0;
                        fill_b_next = '0;
                        i_next      = '0;
                        j_next      = '0;
                        t_next      = '0;
                        rbase_next  = '0;
                        tn_next     = '0;
                        if (mode_reg <= sme_pkg::MODE_SCALE) begin
                            state_next = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (stat.adv) begin
                    iss_next.valid = 1'b1;
                    iss_next.op    = op_cur;
                    iss_next.first = elementwise || (t_reg == '0);
                    iss_next.last  = term_last;
                    iss_next.fin   = term_last && col_last && (i_reg == nm1);
                    iss_next.row   = RB'(i_reg);
                    iss_next.col   = (mode_reg == sme_pkg::MODE_VEC) ? '0 : RB'(j_reg);
                    if (elementwise) begin
                        a_addr_next = rbase_reg + AW'(j_reg);
                        b_addr_next = rbase_reg + AW'(j_reg);
                    end else if (mode_reg == sme_pkg::MODE_VEC) begin
                        a_addr_next = rbase_reg + AW'(t_reg);
                        b_addr_next = AW'(t_reg);
                    end else begin
                        a_addr_next = rbase_reg + AW'(t_reg);
                        b_addr_next = tn_reg + AW'(j_reg);
                    end

                    if (!term_last) begin
                        t_next  = t_reg + IW'(1);
                        tn_next = tn_reg + n_aw;
                    end else begin
                        t_next  = '0;
                        tn_next = '0;
                        if (!col_last) begin
                            j_next = j_reg + IW'(1);
                        end else begin
                            j_next = '0;
                            if (i_reg == nm1) begin
                                state_next = S_DRAIN;
                            end else begin
                                i_next     = i_reg + IW'(1);
                                rbase_next = rbase_reg + n_aw;
                            end
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (stat.adv) begin
                    iss_next.valid = 1'b0;
                end
                if (!iss_reg.valid && !stat.busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            size_reg      <= sme_pkg::SIZE_RESET;
            mode_reg      <= sme_pkg::MODE_MAT;
            scale_reg     <= sme_pkg::SCALE_RESET;
            fill_a_reg    <= '0;
            fill_b_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
            rbase_reg     <= '0;
            tn_reg        <= '0;
            iss_reg       <= '0;
            a_addr_reg    <= '0;
            b_addr_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            mode_reg      <= mode_next;
            scale_reg     <= scale_next;
            fill_a_reg    <= fill_a_next;
            fill_b_reg    <= fill_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            t_reg         <= t_next;
            rbase_reg     <= rbase_next;
            tn_reg        <= tn_next;
            iss_reg       <= iss_next;
            a_addr_reg    <= a_addr_next;
            b_addr_reg    <= b_addr_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign scale_factor = scale_reg;
    assign load_addr    = in_cmd ? fill_b_reg[AW-1:0] : fill_a_reg[AW-1:0];
    assign iss          = iss_reg;
    assign a_addr       = a_addr_reg;
    assign b_addr       = b_addr_reg;

endmodule

`default_nettype wire

@@ hdl/sme_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sme_datapath #(
    parameter int ELEM_BITS = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [ELEM_BITS-1:0]                element,
    input  sme_pkg::load_t                      load,
    input  wire  [sme_pkg::ADDR_W-1:0]          load_addr,
    input  sme_pkg::iss_t                       iss,
    input  wire  [sme_pkg::ADDR_W-1:0]          a_addr,
    input  wire  [sme_pkg::ADDR_W-1:0]          b_addr,
    input  wire  [sme_pkg::SCALE_W-1:0]         scale_factor,
    output sme_pkg::stat_t                      stat,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [sme_pkg::OUT_DATA_W-1:0]      out_data,
    output logic                                out_last
);

    localparam int CAP = sme_pkg::CAPACITY;
    localparam int E   = ELEM_BITS;
    localparam int MW  = (E > sme_pkg::SCALE_W) ? E : sme_pkg::SCALE_W;
    localparam int TW  = E + MW;
    localparam int RW  = sme_pkg::RES_W;
    localparam int SW  = ((TW > RW) ? TW : RW) + 1;
    localparam int RB  = sme_pkg::ROW_BITS;

    logic [E-1:0] mem_a [CAP];
    logic [E-1:0] mem_b [CAP];

    logic [E-1:0]         rd_a_reg;
    logic [E-1:0]         rd_b_reg;
    sme_pkg::iss_t        ctl1_reg;
    sme_pkg::iss_t        ctl2_reg;
    logic signed [TW-1:0] term_reg;
    logic signed [RW-1:0] acc_reg;
    logic                 out_valid_reg;
    logic [RB-1:0]        out_row_reg;
    logic [RB-1:0]        out_col_reg;
    logic [RW-1:0]        out_val_reg;
    logic                 out_fin_reg;

    logic                 adv;
    logic signed [E-1:0]  a_s;
    logic signed [E-1:0]  b_s;
    logic signed [MW-1:0] mul_b;
    logic signed [TW-1:0] prod;
    logic signed [E:0]    a_ext;
    logic signed [E:0]    b_ext;
    logic signed [E:0]    ew;
    logic signed [TW-1:0] term;
    logic signed [RW-1:0] base;
    logic signed [SW-1:0] sum;
    logic [RW-1:0]        sat_val;
    logic [SW-RW:0]       top_bits;

    assign adv = !out_valid_reg || out_ready;

    assign a_s   = signed'(rd_a_reg);
    assign b_s   = signed'(rd_b_reg);
    assign mul_b = (ctl1_reg.op == sme_pkg::OP_SCALE) ? MW'(signed'(scale_factor)) : MW'(b_s);
    assign prod  = a_s * mul_b;
    assign a_ext = {a_s[E-1], a_s};
    assign b_ext = {b_s[E-1], b_s};

    always_comb begin
        case (ctl1_reg.op)
            sme_pkg::OP_ADD: ew = a_ext + b_ext;
            sme_pkg::OP_SUB: ew = a_ext - b_ext;
            default: ew = -a_ext;
        endcase
        case (ctl1_reg.op)
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_NEG: term = TW'(ew) <<< 8;
            default: term = prod;
        endcase
    end

    assign base     = ctl2_reg.first ? '0 : acc_reg;
    assign sum      = SW'(base) + SW'(term_reg);
    assign top_bits = sum[SW-1:RW-1];

    always_comb begin
        if ((top_bits == '0) || (top_bits == '1)) begin
            sat_val = sum[RW-1:0];
        end else if (sum[SW-1]) begin
            sat_val = {1'b1, {(RW-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(RW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (load.we_a) begin
            mem_a[load_addr] <= element;
        end
        if (load.we_b) begin
            mem_b[load_addr] <= element;
        end
        if (adv) begin
            rd_a_reg <= mem_a[a_addr];
            rd_b_reg <= mem_b[b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            term_reg <= term;
            if (ctl2_reg.valid) begin
                acc_reg <= signed'(sat_val);
            end
            if (ctl2_reg.valid && ctl2_reg.last) begin
                out_row_reg <= ctl2_reg.row;
                out_col_reg <= ctl2_reg.col;
                out_val_reg <= sat_val;
                out_fin_reg <= ctl2_reg.fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            ctl1_reg      <= iss;
            ctl2_reg      <= ctl1_reg;
            out_valid_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    assign stat.adv  = adv;
    assign stat.busy = ctl1_reg.valid || ctl2_reg.valid;
    assign out_valid = out_valid_reg;
    assign out_data  = sme_pkg::OUT_DATA_W'({out_val_reg, out_col_reg, out_row_reg});
    assign out_last  = out_fin_reg;

endmodule

`default_nettype wire

@@ hdl/square_matrix_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// s_axis    in         s_axis_tvalid/tready    element, cmd in tuser, last in tlast
// m_axis    out        m_axis_tvalid/tready    row, col, result_value, final_res in tlast
// cfg       in         cfg_valid/cfg_ready     register index and write data
//
// The input is held off from the last load of a run until the run has drained. The single
// multiply-accumulate unit takes one term per cycle while m_axis does not stall: N*N*N
// terms for a matrix product, N*N for a vector product and N*N for the element modes.
// Reset is synchronous and active low and needs no clearing pass. A stall on m_axis
// freezes the whole compute pipeline.

module square_matrix_engine #(
    parameter int ELEM_BITS = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [((ELEM_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // element
    input  wire                                 s_axis_tuser,  // cmd
    input  wire                                 s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [sme_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // row, col, result_value
    output logic                                m_axis_tlast,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [sme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [sme_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = sme_pkg::ADDR_W;

    sme_pkg::load_t              load;
    sme_pkg::iss_t               iss;
    sme_pkg::stat_t              stat;
    logic [AW-1:0]               load_addr;
    logic [AW-1:0]               a_addr;
    logic [AW-1:0]               b_addr;
    logic [sme_pkg::SCALE_W-1:0] scale_factor;

    sme_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .scale_factor(scale_factor),
        .load        (load),
        .load_addr   (load_addr),
        .iss         (iss),
        .a_addr      (a_addr),
        .b_addr      (b_addr),
        .stat        (stat)
    );

    sme_datapath #(
        .ELEM_BITS(ELEM_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .element     (s_axis_tdata[ELEM_BITS-1:0]),
        .load        (load),
        .load_addr   (load_addr),
        .iss         (iss),
        .a_addr      (a_addr),
        .b_addr      (b_addr),
        .scale_factor(scale_factor),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ bench/sme_tb_pkg.sv @@
`timescale 1ns / 1ps

package sme_tb_pkg;

    localparam int DIM_MAX     = 8;
    localparam int STORE_DEPTH = DIM_MAX * DIM_MAX;
    localparam int ELEM_W      = 16;

    localparam logic CMD_LOAD_A = 1'b0;
    localparam logic CMD_LOAD_B = 1'b1;

    localparam logic [sme_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [sme_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [sme_pkg::ROW_BITS-1:0]  row;
        logic [sme_pkg::ROW_BITS-1:0]  col;
        logic signed [sme_pkg::RES_W-1:0] value;
        logic                          fin;
    } result_t;

endpackage

@@ bench/sme_checker.sv @@
`timescale 1ns / 1ps

module sme_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_axis_tvalid,
    input  wire                            s_axis_tready,
    input  wire  [15:0]                    s_axis_tdata,
    input  wire                            s_axis_tuser,
    input  wire                            s_axis_tlast,
    input  wire                            m_axis_tvalid,
    input  wire                            m_axis_tready,
    input  wire  [sme_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                            m_axis_tlast,
    input  wire                            cfg_valid,
    input  wire                            cfg_ready,
    input  wire  [sme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [sme_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             results_checked
);

    import sme_pkg::*;
    import sme_tb_pkg::*;

    localparam longint RES_HI = (64'sd1 <<< (RES_W - 1)) - 1;
    localparam longint RES_LO = -(64'sd1 <<< (RES_W - 1));

    logic signed [ELEM_W-1:0]  store_a [STORE_DEPTH];
    logic signed [ELEM_W-1:0]  store_b [STORE_DEPTH];
    int                        fill_a;
    int                        fill_b;
    logic [SIZE_W-1:0]         dim_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    result_t                   product_q [$];

    function automatic longint clamp_q16(longint v);
        if (v > RES_HI) begin
            return RES_HI;
        end
        if (v < RES_LO) begin
            return RES_LO;
        end
        return v;
    endfunction

    task automatic queue_product(int r, int c, longint v, bit fin);
        result_t e;
        e.row   = r[ROW_BITS-1:0];
        e.col   = c[ROW_BITS-1:0];
        e.value = v[RES_W-1:0];
        e.fin   = fin;
        product_q.push_back(e);
    endtask

    task automatic predict_products();
        int     n;
        int     p;
        longint acc;
        n = (dim_reg == 0) ? 1 : (dim_reg > DIM_MAX) ? DIM_MAX : int'(dim_reg);
        if (mode_reg == MODE_VEC) begin
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int t = 0; t < n; t++) begin
                    acc = clamp_q16(acc + longint'(store_a[i*n+t]) * longint'(store_b[t]));
                end
                queue_product(i, 0, acc, i == n - 1);
            end
        end else if (mode_reg <= MODE_SCALE) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    p   = i * n + j;
                    acc = 0;
                    case (mode_reg)
                        MODE_MAT: begin
                            for (int t = 0; t < n; t++) begin
                                acc = clamp_q16(acc + longint'(store_a[i*n+t])
                                                    * longint'(store_b[t*n+j]));
                            end
                        end
                        MODE_ADD: begin
                            acc = clamp_q16((longint'(store_a[p]) + longint'(store_b[p])) * 256);
                        end
                        MODE_SUB: begin
                            acc = clamp_q16((longint'(store_a[p]) - longint'(store_b[p])) * 256);
                        end
                        MODE_NEG: begin
                            acc = clamp_q16(-longint'(store_a[p]) * 256);
                        end
                        default: begin
                            acc = clamp_q16(longint'(store_a[p]) * longint'(scale_reg));
                        end
                    endcase
                    queue_product(i, j, acc, (i == n - 1) && (j == n - 1));
                end
            end
        end
    endtask

    task automatic check_product();
        result_t got;
        result_t want;
        got.row   = m_axis_tdata[ROW_BITS-1:0];
        got.col   = m_axis_tdata[ROW_BITS +: ROW_BITS];
        got.value = m_axis_tdata[2*ROW_BITS +: RES_W];
        got.fin   = m_axis_tlast;
        results_checked++;
        if (product_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result transfer: row %0d col %0d value %0d last %0d",
                         got.row, got.col, got.value, got.fin);
            end
        end else begin
            want = product_q.pop_front();
            if (got.row != want.row || got.col != want.col || got.value != want.value
                    || got.fin != want.fin) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch: expected row %0d col %0d value %0d last %0d",
                             want.row, want.col, want.value, want.fin);
                    $display("                 got      row %0d col %0d value %0d last %0d",
                             got.row, got.col, got.value, got.fin);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                store_a[k] = '0;
                store_b[k] = '0;
            end
            fill_a          = 0;
            fill_b          = 0;
            dim_reg         = SIZE_RESET;
            mode_reg        = MODE_MAT;
            scale_reg       = SCALE_RESET;
            mismatches      = 0;
            results_checked = 0;
            product_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SIZE:  dim_reg   = cfg_data[SIZE_W-1:0];
                    REG_MODE:  mode_reg  = cfg_data[MODE_W-1:0];
                    REG_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_LOAD_A) begin
                    if (fill_a < STORE_DEPTH) begin
                        store_a[fill_a] = s_axis_tdata;
                        fill_a++;
                    end
                end else if (fill_b < STORE_DEPTH) begin
                    store_b[fill_b] = s_axis_tdata;
                    fill_b++;
                end
                if (s_axis_tlast) begin
                    fill_a = 0;
                    fill_b = 0;
                    predict_products();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_product();
            end
        end
        pending = product_q.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import sme_pkg::*;
    import sme_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int ITEM_TARGET  = 430;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 600;
    localparam int RUN_CLEAN    = 0;
    localparam int RUN_BROKEN   = 1;
    localparam int RUN_OVERFILL = 2;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic [15:0]             s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tready = 1'b0;
    logic                    cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;
    wire                     s_axis_tready;
    wire                     m_axis_tvalid;
    wire  [OUT_DATA_W-1:0]   m_axis_tdata;
    wire                     m_axis_tlast;
    wire                     cfg_ready;

    int                mismatches;
    int                pending;
    int                results_checked;
    int                cycle_count     = 0;
    int                loads_sent      = 0;
    int                runs_sent       = 0;
    int                hold_request    = 0;
    int                runs_per_mode [8];
    bit                no_gaps         = 1'b0;
    bit                last_run_silent = 1'b0;
    logic [SIZE_W-1:0] dim_now         = SIZE_RESET;
    logic [MODE_W-1:0] mode_now        = MODE_MAT;
    int                fill_a          = 0;
    int                fill_b          = 0;
    bit                written_a [STORE_DEPTH];
    bit                written_b [STORE_DEPTH];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    square_matrix_engine uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sme_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Result sink: random ready pattern, or one long hold-off when requested.
    initial begin : result_sink
        int len;
        int pick;
        @(negedge aclk);
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_request > 0) begin
                len          = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
            end else if (no_gaps || pick < 70) begin
                len = $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
            end else if (pick < 95) begin
                len = $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
            end else begin
                len = $urandom_range(15, 40);
                m_axis_tready <= 1'b0;
            end
            repeat (len) @(negedge aclk);
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60) begin
            return 0;
        end
        if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_element();
        if ($urandom_range(0, 99) < 20) begin
            case ($urandom_range(0, 4))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic send_load(logic cmd, logic [15:0] elem, logic last);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= elem;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        loads_sent++;
        if (cmd == CMD_LOAD_A) begin
            if (fill_a < STORE_DEPTH) begin
                written_a[fill_a] = 1'b1;
                fill_a++;
            end
        end else if (fill_b < STORE_DEPTH) begin
            written_b[fill_b] = 1'b1;
            fill_b++;
        end
        if (last) begin
            fill_a = 0;
            fill_b = 0;
            runs_sent++;
            runs_per_mode[mode_now]++;
            last_run_silent = (mode_now > MODE_SCALE);
        end
    endtask

    // Waits for every outstanding result, plus time for a run that produces none.
    task automatic settle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (last_run_silent ? TAIL_CYCLES : 8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SIZE: dim_now  = value[SIZE_W-1:0];
            REG_MODE: mode_now = value[MODE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_run(int kind);
        int n;
        int need_a;
        int need_b;
        int cnt_a;
        int cnt_b;
        n = (dim_now == 0) ? 1 : (dim_now > DIM_MAX) ? DIM_MAX : int'(dim_now);
        case (mode_now)
            MODE_MAT, MODE_ADD, MODE_SUB: begin
                need_a = n * n;
                need_b = n * n;
            end
            MODE_VEC: begin
                need_a = n * n;
                need_b = n;
            end
            MODE_NEG, MODE_SCALE: begin
                need_a = n * n;
                need_b = 0;
            end
            default: begin
                need_a = 0;
                need_b = 0;
            end
        endcase
        cnt_a = need_a;
        cnt_b = need_b;
        if (kind == RUN_BROKEN) begin
            // A short run may only rely on entries that earlier runs have written.
            cnt_a = $urandom_range(0, need_a + 3);
            cnt_b = $urandom_range(0, need_b + 3);
            for (int k = cnt_a; k < need_a; k++) begin
                if (!written_a[k]) begin
                    cnt_a = need_a;
                end
            end
            for (int k = cnt_b; k < need_b; k++) begin
                if (!written_b[k]) begin
                    cnt_b = need_b;
                end
            end
        end else if (kind == RUN_OVERFILL) begin
            cnt_a = STORE_DEPTH + $urandom_range(1, 4);
        end
        if (cnt_a + cnt_b == 0) begin
            cnt_a = 1;
        end
        while (cnt_a + cnt_b > 0) begin
            if (cnt_b > 0 && (cnt_a == 0 || kind == RUN_OVERFILL || $urandom_range(0, 1) == 1))
            begin
                cnt_b--;
                send_load(CMD_LOAD_B, pick_element(), cnt_a + cnt_b == 0);
            end else begin
                cnt_a--;
                send_load(CMD_LOAD_A, pick_element(), cnt_a + cnt_b == 0);
            end
        end
    endtask

    task automatic new_setting();
        int                 pick;
        logic [SIZE_W-1:0]  dim;
        logic [MODE_W-1:0]  md;
        logic [SCALE_W-1:0] sc;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            dim = SIZE_W'($urandom_range(1, 3));
        end else if (pick < 80) begin
            dim = SIZE_W'($urandom_range(4, 7));
        end else if (pick < 92) begin
            dim = SIZE_W'(DIM_MAX);
        end else begin
            dim = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(9, 15));
        end
        if ($urandom_range(0, 99) < 8) begin
            md = ($urandom_range(0, 1) == 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
        end else begin
            md = MODE_W'($urandom_range(0, 5));
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0:       sc = 16'h7FFF;
                1:       sc = 16'h8000;
                2:       sc = 16'h0000;
                3:       sc = 16'hFFFF;
                default: sc = SCALE_RESET;
            endcase
        end else begin
            sc = 16'($urandom);
        end
        if ($urandom_range(0, 9) < 7) begin
            write_reg(REG_SIZE, CFG_DATA_W'(dim));
        end
        write_reg(REG_MODE, CFG_DATA_W'(md));
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_SCALE, sc);
        end
    endtask

    initial begin : stimulus
        int base;
        int phase;
        int failures;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Extremes of every operation on one- and two-element operands.
        write_reg(REG_SIZE, 16'd1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_MAT));
        send_load(CMD_LOAD_A, 16'h7FFF, 1'b0);
        send_load(CMD_LOAD_B, 16'h8000, 1'b1);
        send_load(CMD_LOAD_B, 16'h8000, 1'b0);
        send_load(CMD_LOAD_A, 16'h8000, 1'b1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_ADD));
        send_load(CMD_LOAD_A, 16'h7FFF, 1'b0);
        send_load(CMD_LOAD_B, 16'h7FFF, 1'b1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SUB));
        send_load(CMD_LOAD_A, 16'h8000, 1'b0);
        send_load(CMD_LOAD_B, 16'h7FFF, 1'b1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_NEG));
        send_load(CMD_LOAD_A, 16'h8000, 1'b1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SCALE));
        write_reg(REG_SCALE, 16'h8000);
        send_load(CMD_LOAD_A, 16'h8000, 1'b1);
        write_reg(REG_SCALE, 16'h7FFF);
        send_load(CMD_LOAD_A, 16'h8000, 1'b1);
        write_reg(REG_SIZE, 16'd2);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_VEC));
        send_load(CMD_LOAD_A, 16'h7FFF, 1'b0);
        send_load(CMD_LOAD_A, 16'h8000, 1'b0);
        send_load(CMD_LOAD_A, 16'hFFFF, 1'b0);
        send_load(CMD_LOAD_A, 16'h0001, 1'b0);
        send_load(CMD_LOAD_B, 16'h8000, 1'b0);
        send_load(CMD_LOAD_B, 16'h7FFF, 1'b1);
        write_reg(REG_SIZE, 16'd0);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_ADD));
        send_load(CMD_LOAD_B, 16'h5A5A, 1'b1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE_LO));
        send_load(CMD_LOAD_A, 16'hFFFF, 1'b1);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE_HI));
        send_load(CMD_LOAD_B, 16'h0000, 1'b0);
        send_load(CMD_LOAD_B, 16'h0001, 1'b1);

        base  = loads_sent;
        phase = 0;
        while (loads_sent - base < ITEM_TARGET) begin
            phase++;
            if (phase == 3) begin
                // The sink holds off while runs keep coming, so the engine backs up.
                write_reg(REG_SIZE, 16'd3);
                write_reg(REG_MODE, CFG_DATA_W'(MODE_MAT));
                no_gaps      = 1'b1;
                hold_request = LONG_HOLD;
                repeat (3) send_run(RUN_CLEAN);
            end else if (phase == 6) begin
                write_reg(REG_MODE, CFG_DATA_W'(MODE_NEG));
                no_gaps = 1'b0;
                send_run(RUN_OVERFILL);
            end else begin
                new_setting();
                no_gaps = ($urandom_range(0, 4) == 0);
                repeat ($urandom_range(1, 3)) begin
                    send_run(($urandom_range(0, 4) == 0) ? RUN_BROKEN : RUN_CLEAN);
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        failures = mismatches + pending;
        if (pending != 0) begin
            $display("%0d expected results never arrived.", pending);
        end
        $display("Sent %0d loads in %0d runs and compared %0d results in %0d cycles.",
                 loads_sent, runs_sent, results_checked, cycle_count);
        $display("Runs by mode: mat %0d, vec %0d, add %0d, sub %0d, neg %0d, scale %0d, spare %0d.",
                 runs_per_mode[0], runs_per_mode[1], runs_per_mode[2], runs_per_mode[3],
                 runs_per_mode[4], runs_per_mode[5], runs_per_mode[6] + runs_per_mode[7]);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
